>>> sv/peshg_pkg.sv
// shared types, constants and byte helpers for the pes header generator
package peshg_pkg;

  localparam int TsW         = 33;
  localparam int LenW        = 16;
  localparam int PosW        = 6;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 8;

  localparam logic [5:0] FixedLenMax = 6'd55;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_PES_SID       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_EXTENDED_ID   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FULL_HEADER   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EXT_ID_ENABLE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DATA_ALIGNED  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FIXED_HDR_LEN = 3'd5;

  localparam logic [7:0] StreamIdReset  = 8'hE0;
  localparam logic [7:0] ByteStartHi    = 8'h00;
  localparam logic [7:0] ByteStartLo    = 8'h01;
  localparam logic [7:0] ByteFlag1      = 8'h81;
  localparam logic [7:0] BitAligned     = 8'h04;
  localparam logic [7:0] FlagsPtsDts    = 8'hC0;
  localparam logic [7:0] FlagsPtsOnly   = 8'h80;
  localparam logic [7:0] FlagExtension  = 8'h01;
  localparam logic [7:0] ByteExtFlags   = 8'h0F;
  localparam logic [7:0] ByteExtLen     = 8'h81;
  localparam logic [7:0] ByteStuff      = 8'hFF;

  localparam logic [3:0] PrefixPtsOfTwo = 4'h3;
  localparam logic [3:0] PrefixDts      = 4'h1;
  localparam logic [3:0] PrefixPtsOnly  = 4'h2;

  typedef struct packed {
    logic [7:0] pes_sid;
    logic [7:0] extended_id;
    logic       full_header;
    logic       ext_id_enable;
    logic       data_aligned;
    logic [5:0] fixed_hdr_len;
  } cfg_t;

  // one classified request waiting for byte generation
  typedef struct packed {
    logic [TsW-1:0]  pts;
    logic [TsW-1:0]  dts;
    logic            both;
    logic            pts_only;
    logic [5:0]      hdr_data_len;
    logic [PosW-1:0] last_idx;
    logic [LenW-1:0] len_field;
  } desc_t;

  function automatic logic [7:0] ts_byte(input logic [3:0] prefix,
                                         input logic [TsW-1:0] ts,
                                         input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = {prefix, ts[32:30], 1'b1};
      3'd1:    b = ts[29:22];
      3'd2:    b = {ts[21:15], 1'b1};
      3'd3:    b = ts[14:7];
      3'd4:    b = {ts[6:0], 1'b1};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/peshg_front.sv
// request front end: timestamp choice, header length and packet length field
module peshg_front (
  input  logic                      start,
  input  logic                      queue_full,
  input  peshg_pkg::cfg_t           cfg,
  input  logic [peshg_pkg::TsW-1:0] in_pts_value,
  input  logic                      in_pts_known,
  input  logic [peshg_pkg::TsW-1:0] in_dts_value,
  input  logic                      in_dts_known,
  input  logic [15:0]               in_payload_bytes,
  output logic                      push,
  output peshg_pkg::desc_t          desc
);

  logic       both;
  logic       pts_only;
  logic [4:0] content_len;
  logic [5:0] fixed_sat;
  logic [6:0] fixed_total;
  logic [6:0] hdr_len;
  logic [6:0] len_add;

  always_comb begin
    both        = in_pts_known && in_dts_known && (in_pts_value != in_dts_value);
    pts_only    = !both && in_pts_known;
    content_len = 5'd9 + (both ? 5'd10 : (pts_only ? 5'd5 : 5'd0))
                + (cfg.ext_id_enable ? 5'd3 : 5'd0);
    fixed_sat   = (cfg.fixed_hdr_len > peshg_pkg::FixedLenMax) ?
                  peshg_pkg::FixedLenMax : cfg.fixed_hdr_len;
    fixed_total = {1'b0, fixed_sat} + 7'd9;
    // a fixed length below the content is ignored
    if (fixed_sat != 6'd0 && {2'b00, content_len} <= fixed_total) begin
      hdr_len = fixed_total;
    end else begin
      hdr_len = {2'b00, content_len};
    end
    len_add = cfg.full_header ? (hdr_len - 7'd6) : 7'd0;

    push              = start && !queue_full;
    desc.pts          = in_pts_value;
    desc.dts          = in_dts_value;
    desc.both         = both;
    desc.pts_only     = pts_only;
    desc.hdr_data_len = 6'(hdr_len - 7'd9);
    desc.last_idx     = cfg.full_header ? 6'(hdr_len - 7'd1) : 6'd5;
    desc.len_field    = (in_payload_bytes != 16'd0) ?
                        (in_payload_bytes + {9'd0, len_add}) : 16'd0;
  end

endmodule

>>> sv/peshg_queue.sv
// two-entry request queue between front end and byte generator
module peshg_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  peshg_pkg::desc_t push_desc,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output peshg_pkg::desc_t head
);

  peshg_pkg::desc_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == 2'd2);
    empty      = (count_r == 2'd0);
    head       = entry_r[rd_ptr_r];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> sv/peshg_back.sv
// byte generator: walks the head request one header byte per cycle
module peshg_back (
  input  logic             clk,
  input  logic             rst_n,
  input  peshg_pkg::cfg_t  cfg,
  input  logic             empty,
  input  peshg_pkg::desc_t head,
  output logic             pop,
  output logic             out_valid,
  output logic [7:0]       out_header_byte,
  output logic             out_last_byte
);

  logic [peshg_pkg::PosW-1:0] pos_r, pos_nxt;
  logic                       valid_r;
  logic [7:0]                 byte_r, byte_nxt;
  logic                       last_r;
  logic                       is_last;
  logic [3:0]                 ts_len;
  logic [5:0]                 k;
  logic [5:0]                 e;
  logic [7:0]                 flags;

  always_comb begin
    is_last = (pos_r == head.last_idx);
    pop     = !empty && is_last;
    pos_nxt = empty ? pos_r : (is_last ? '0 : pos_r + 6'd1);
    ts_len  = head.both ? 4'd10 : (head.pts_only ? 4'd5 : 4'd0);
    k       = pos_r - 6'd9;
    e       = k - {2'b00, ts_len};
    flags   = (head.both ? peshg_pkg::FlagsPtsDts :
               (head.pts_only ? peshg_pkg::FlagsPtsOnly : 8'h00))
            | (cfg.ext_id_enable ? peshg_pkg::FlagExtension : 8'h00);
    case (pos_r)
      6'd0:    byte_nxt = peshg_pkg::ByteStartHi;
      6'd1:    byte_nxt = peshg_pkg::ByteStartHi;
      6'd2:    byte_nxt = peshg_pkg::ByteStartLo;
      6'd3:    byte_nxt = cfg.pes_sid;
      6'd4:    byte_nxt = head.len_field[15:8];
      6'd5:    byte_nxt = head.len_field[7:0];
      6'd6:    byte_nxt = peshg_pkg::ByteFlag1
                        | (cfg.data_aligned ? peshg_pkg::BitAligned : 8'h00);
      6'd7:    byte_nxt = flags;
      6'd8:    byte_nxt = {2'b00, head.hdr_data_len};
      default: begin
        if (k < {2'b00, ts_len}) begin
          // first timestamp is the pts, second one the dts
          if (k < 6'd5) begin
            byte_nxt = peshg_pkg::ts_byte(head.both ? peshg_pkg::PrefixPtsOfTwo :
                                          peshg_pkg::PrefixPtsOnly,
                                          head.pts, k[2:0]);
          end else begin
            byte_nxt = peshg_pkg::ts_byte(peshg_pkg::PrefixDts, head.dts,
                                          3'(k - 6'd5));
          end
        end else if (cfg.ext_id_enable && e == 6'd0) begin
          byte_nxt = peshg_pkg::ByteExtFlags;
        end else if (cfg.ext_id_enable && e == 6'd1) begin
          byte_nxt = peshg_pkg::ByteExtLen;
        end else if (cfg.ext_id_enable && e == 6'd2) begin
          byte_nxt = cfg.extended_id;
        end else begin
          byte_nxt = peshg_pkg::ByteStuff;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= is_last;
  end

  assign out_valid       = valid_r;
  assign out_header_byte = byte_r;
  assign out_last_byte   = last_r;

endmodule

>>> sv/pes_header_generator.sv
// pes header generator top level: config registers, front end, queue, byte generator
// with the byte generator idle, a taken request is written into the queue, its first
// header byte is registered by the byte generator, then one byte per cycle
// a request's header is 6 to 64 bytes long, set by its header length
// a two-entry request queue lets new requests in while a header is being sent
// busy is high only while that queue is full; cfg_ready is always high
// synchronous active-low reset clears the queue and the byte counter and sets the registers to their defaults
module pes_header_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [peshg_pkg::TsW-1:0]      in_pts_value,
  input  logic                           in_pts_known,
  input  logic [peshg_pkg::TsW-1:0]      in_dts_value,
  input  logic                           in_dts_known,
  input  logic [15:0]                    in_payload_bytes,
  output logic                           out_valid,
  output logic [7:0]                     out_header_byte,
  output logic                           out_last_byte,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [peshg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [peshg_pkg::CfgDataW-1:0] cfg_data
);

  peshg_pkg::cfg_t  cfg_r, cfg_nxt;
  peshg_pkg::desc_t front_desc;
  peshg_pkg::desc_t head;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        peshg_pkg::REG_PES_SID:       cfg_nxt.pes_sid       = cfg_data;
        peshg_pkg::REG_EXTENDED_ID:   cfg_nxt.extended_id   = cfg_data;
        peshg_pkg::REG_FULL_HEADER:   cfg_nxt.full_header   = cfg_data[0];
        peshg_pkg::REG_EXT_ID_ENABLE: cfg_nxt.ext_id_enable = cfg_data[0];
        peshg_pkg::REG_DATA_ALIGNED:  cfg_nxt.data_aligned  = cfg_data[0];
        peshg_pkg::REG_FIXED_HDR_LEN: cfg_nxt.fixed_hdr_len = cfg_data[5:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pes_sid       <= peshg_pkg::StreamIdReset;
      cfg_r.extended_id   <= 8'h00;
      cfg_r.full_header   <= 1'b1;
      cfg_r.ext_id_enable <= 1'b0;
      cfg_r.data_aligned  <= 1'b0;
      cfg_r.fixed_hdr_len <= 6'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  peshg_front u_front (
    .start            (start),
    .queue_full       (full),
    .cfg              (cfg_r),
    .in_pts_value     (in_pts_value),
    .in_pts_known     (in_pts_known),
    .in_dts_value     (in_dts_value),
    .in_dts_known     (in_dts_known),
    .in_payload_bytes (in_payload_bytes),
    .push             (push),
    .desc             (front_desc)
  );

  peshg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (front_desc),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  peshg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .empty           (empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_header_byte (out_header_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule

>>> test/pes_header_generator_tb.sv
// self-checking testbench for the pes header generator: directed and random requests
`timescale 1ns / 100ps

module pes_header_generator_tb;

  localparam int CycleLimit    = 200000;
  localparam int SettleCycles  = 8;
  localparam int RandPhases    = 9;
  localparam int ItemsPerPhase = 28;

  typedef struct packed {
    logic [peshg_pkg::TsW-1:0] pts;
    logic                      pts_known;
    logic [peshg_pkg::TsW-1:0] dts;
    logic                      dts_known;
    logic [15:0]               payload;
  } pes_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hdr_byte_t;

  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           start            = 1'b0;
  logic                           busy;
  logic [peshg_pkg::TsW-1:0]      in_pts_value     = '0;
  logic                           in_pts_known     = 1'b0;
  logic [peshg_pkg::TsW-1:0]      in_dts_value     = '0;
  logic                           in_dts_known     = 1'b0;
  logic [15:0]                    in_payload_bytes = '0;
  logic                           out_valid;
  logic [7:0]                     out_header_byte;
  logic                           out_last_byte;
  logic                           cfg_valid        = 1'b0;
  logic                           cfg_ready;
  logic [peshg_pkg::CfgIdxW-1:0]  cfg_index        = '0;
  logic [peshg_pkg::CfgDataW-1:0] cfg_data         = '0;

  peshg_pkg::cfg_t cfg_shadow;
  pes_req_t        req_q[$];
  hdr_byte_t       hdr_bytes_q[$];
  pes_req_t        cur_req;
  hdr_byte_t       want_b;
  int              gap_left  = 0;
  bit              no_gaps   = 1'b0;
  int              err_cnt   = 0;
  int              req_cnt   = 0;
  int              byte_cnt  = 0;
  int              hdr_cnt   = 0;
  int              cfg_cnt   = 0;
  int              cycle_cnt = 0;

  pes_header_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_pts_value     (in_pts_value),
    .in_pts_known     (in_pts_known),
    .in_dts_value     (in_dts_value),
    .in_dts_known     (in_dts_known),
    .in_payload_bytes (in_payload_bytes),
    .out_valid        (out_valid),
    .out_header_byte  (out_header_byte),
    .out_last_byte    (out_last_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // marker bits sit between the timestamp pieces
  function automatic logic [39:0] stamp_word(input logic [3:0] prefix,
                                             input logic [peshg_pkg::TsW-1:0] ts);
    return {prefix, ts[32:30], 1'b1, ts[29:15], 1'b1, ts[14:0], 1'b1};
  endfunction

  task automatic predict_header(input pes_req_t r);
    logic [7:0]  hb[$];
    logic        both;
    logic        pts_only;
    logic [79:0] stamps;
    logic [7:0]  flags;
    int          n_stamp;
    int          fixed;
    int          hdr_len;
    logic [15:0] len_field;
    both     = r.pts_known && r.dts_known && (r.pts != r.dts);
    pts_only = !both && r.pts_known;
    fixed    = (cfg_shadow.fixed_hdr_len > peshg_pkg::FixedLenMax) ?
               int'(peshg_pkg::FixedLenMax) : int'(cfg_shadow.fixed_hdr_len);
    n_stamp  = both ? 10 : (pts_only ? 5 : 0);
    hdr_len  = 6;
    if (cfg_shadow.full_header) begin
      hdr_len = 9 + n_stamp + (cfg_shadow.ext_id_enable ? 3 : 0);
      // a fixed length shorter than the content is ignored
      if (fixed != 0 && hdr_len <= fixed + 9) hdr_len = fixed + 9;
    end
    len_field = (r.payload != 16'd0) ? 16'(hdr_len + int'(r.payload) - 6) : 16'h0000;

    hb.push_back(peshg_pkg::ByteStartHi);
    hb.push_back(peshg_pkg::ByteStartHi);
    hb.push_back(peshg_pkg::ByteStartLo);
    hb.push_back(cfg_shadow.pes_sid);
    hb.push_back(len_field[15:8]);
    hb.push_back(len_field[7:0]);
    if (cfg_shadow.full_header) begin
      hb.push_back(peshg_pkg::ByteFlag1 |
                   (cfg_shadow.data_aligned ? peshg_pkg::BitAligned : 8'h00));
      flags = both ? peshg_pkg::FlagsPtsDts : (pts_only ? peshg_pkg::FlagsPtsOnly : 8'h00);
      hb.push_back(flags | (cfg_shadow.ext_id_enable ? peshg_pkg::FlagExtension : 8'h00));
      hb.push_back(8'(hdr_len - 9));
      stamps = both ? {stamp_word(peshg_pkg::PrefixPtsOfTwo, r.pts),
                       stamp_word(peshg_pkg::PrefixDts, r.dts)}
                    : {stamp_word(peshg_pkg::PrefixPtsOnly, r.pts), 40'h0};
      for (int k = 0; k < n_stamp; k++) hb.push_back(stamps[79-8*k -: 8]);
      if (cfg_shadow.ext_id_enable) begin
        hb.push_back(peshg_pkg::ByteExtFlags);
        hb.push_back(peshg_pkg::ByteExtLen);
        hb.push_back(cfg_shadow.extended_id);
      end
      while (hb.size() < hdr_len) hb.push_back(peshg_pkg::ByteStuff);
    end
    for (int k = 0; k < hb.size(); k++)
      hdr_bytes_q.push_back('{data: hb[k], last: (k == hb.size() - 1)});
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pes_req_t mk_req(input logic [peshg_pkg::TsW-1:0] pts,
                                      input logic pk,
                                      input logic [peshg_pkg::TsW-1:0] dts,
                                      input logic dk,
                                      input logic [15:0] payload);
    pes_req_t r;
    r.pts       = pts;
    r.pts_known = pk;
    r.dts       = dts;
    r.dts_known = dk;
    r.payload   = payload;
    return r;
  endfunction

  function automatic pes_req_t rand_req();
    pes_req_t r;
    r.pts       = {1'($urandom_range(0, 1)), 32'($urandom())};
    // equal timestamps collapse to pts alone, so hit them often
    r.dts       = ($urandom_range(0, 3) == 0) ? r.pts
                                              : {1'($urandom_range(0, 1)), 32'($urandom())};
    r.pts_known = ($urandom_range(0, 3) != 0);
    r.dts_known = ($urandom_range(0, 2) != 0);
    case ($urandom_range(0, 9))
      0:       r.payload = 16'h0000;
      1:       r.payload = 16'hFFFF - 16'($urandom_range(0, 80));
      default: r.payload = 16'($urandom());
    endcase
    return r;
  endfunction

  // driver: one request transfer per start && !busy edge
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_header(cur_req);
        req_cnt++;
        gap_left = no_gaps ? 0 : pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_pts_value     <= cur_req.pts;
          in_pts_known     <= cur_req.pts_known;
          in_dts_value     <= cur_req.dts;
          in_dts_known     <= cur_req.dts_known;
          in_payload_bytes <= cur_req.payload;
          start            <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: compare every strobed byte against the oldest predicted byte
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (hdr_bytes_q.size() == 0) begin
        $error("unexpected header byte %h (last_byte %b)", out_header_byte, out_last_byte);
        err_cnt++;
      end else begin
        want_b = hdr_bytes_q.pop_front();
        byte_cnt++;
        if (out_header_byte !== want_b.data) begin
          $error("header_byte: expected %h, actual %h", want_b.data, out_header_byte);
          err_cnt++;
        end
        if (out_last_byte !== want_b.last) begin
          $error("last_byte: expected %b, actual %b", want_b.last, out_last_byte);
          err_cnt++;
        end
        if (want_b.last) hdr_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still pending",
               cycle_cnt, hdr_bytes_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [peshg_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      peshg_pkg::REG_PES_SID:       cfg_shadow.pes_sid       = val;
      peshg_pkg::REG_EXTENDED_ID:   cfg_shadow.extended_id   = val;
      peshg_pkg::REG_FULL_HEADER:   cfg_shadow.full_header   = val[0];
      peshg_pkg::REG_EXT_ID_ENABLE: cfg_shadow.ext_id_enable = val[0];
      peshg_pkg::REG_DATA_ALIGNED:  cfg_shadow.data_aligned  = val[0];
      peshg_pkg::REG_FIXED_HDR_LEN: cfg_shadow.fixed_hdr_len = val[5:0];
      default: ;
    endcase
    cfg_cnt++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (req_q.size() != 0 || start || hdr_bytes_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    cfg_shadow = '{pes_sid: peshg_pkg::StreamIdReset, extended_id: 8'h00,
                   full_header: 1'b1, ext_id_enable: 1'b0, data_aligned: 1'b0,
                   fixed_hdr_len: 6'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: timestamp selection and length field corners
    req_q.push_back(mk_req(33'h1FFFFFFFF, 1'b1, 33'h000000000, 1'b1, 16'hFFFF));
    req_q.push_back(mk_req(33'h000000000, 1'b1, 33'h1FFFFFFFF, 1'b1, 16'd1));
    req_q.push_back(mk_req(33'h0AAAAAAAA, 1'b1, 33'h0AAAAAAAA, 1'b1, 16'd100));
    req_q.push_back(mk_req(33'h155555555, 1'b0, 33'h0ABCDEF01, 1'b1, 16'd0));
    req_q.push_back(mk_req(33'h000000000, 1'b0, 33'h000000000, 1'b0, 16'd0));
    req_q.push_back(mk_req(33'h123456789, 1'b1, 33'h000000000, 1'b0, 16'hFFF5));
    wait_idle();

    // extension and alignment on, all-ones ids
    write_reg(peshg_pkg::REG_PES_SID, 8'hFF);
    write_reg(peshg_pkg::REG_EXTENDED_ID, 8'hFF);
    write_reg(peshg_pkg::REG_EXT_ID_ENABLE, 8'h01);
    write_reg(peshg_pkg::REG_DATA_ALIGNED, 8'h01);
    req_q.push_back(mk_req(33'h0F0F0F0F0, 1'b1, 33'h10F0F0F0F, 1'b1, 16'd1000));
    req_q.push_back(mk_req(33'h1DEADBEEF, 1'b1, 33'h000000001, 1'b0, 16'h8000));
    req_q.push_back(mk_req(33'h000000000, 1'b0, 33'h000000000, 1'b0, 16'd7));
    wait_idle();

    // largest stuffing gives a 64-byte header
    write_reg(peshg_pkg::REG_FIXED_HDR_LEN, 8'd55);
    req_q.push_back(mk_req(33'h1FFFFFFFF, 1'b1, 33'h0FFFFFFFF, 1'b1, 16'd5));
    req_q.push_back(mk_req(33'h000000000, 1'b0, 33'h000000000, 1'b0, 16'hFFFF));
    wait_idle();

    // out-of-range fixed length saturates
    write_reg(peshg_pkg::REG_FIXED_HDR_LEN, 8'd63);
    req_q.push_back(mk_req(33'h012345678, 1'b1, 33'h087654321, 1'b1, 16'd3));
    wait_idle();

    // fixed length below the content is ignored
    write_reg(peshg_pkg::REG_FIXED_HDR_LEN, 8'd1);
    req_q.push_back(mk_req(33'h000000000, 1'b0, 33'h000000000, 1'b0, 16'd20));
    req_q.push_back(mk_req(33'h111111111, 1'b1, 33'h022222222, 1'b1, 16'd20));
    wait_idle();
    write_reg(peshg_pkg::REG_EXT_ID_ENABLE, 8'h00);
    req_q.push_back(mk_req(33'h000000000, 1'b0, 33'h1FFFFFFFF, 1'b1, 16'd20));
    wait_idle();
    write_reg(peshg_pkg::REG_FIXED_HDR_LEN, 8'd5);
    req_q.push_back(mk_req(33'h1AAAAAAAA, 1'b1, 33'h1AAAAAAAA, 1'b0, 16'd20));
    wait_idle();

    // short header only
    write_reg(peshg_pkg::REG_FULL_HEADER, 8'h00);
    write_reg(peshg_pkg::REG_PES_SID, 8'h00);
    req_q.push_back(mk_req(33'h1FFFFFFFF, 1'b1, 33'h000000000, 1'b1, 16'hFFFF));
    req_q.push_back(mk_req(33'h000000000, 1'b0, 33'h000000000, 1'b0, 16'd1));
    wait_idle();

    for (int p = 0; p < RandPhases; p++) begin
      int fx;
      fx = $urandom_range(0, 9);
      fx = (fx < 3) ? 0 : ((fx < 5) ? $urandom_range(56, 63) : $urandom_range(0, 63));
      write_reg(peshg_pkg::REG_PES_SID, 8'($urandom()));
      write_reg(peshg_pkg::REG_EXTENDED_ID, 8'($urandom()));
      write_reg(peshg_pkg::REG_FULL_HEADER,
                {7'($urandom()), 1'(($urandom_range(0, 4) != 0) || (p == 0))});
      write_reg(peshg_pkg::REG_EXT_ID_ENABLE, 8'($urandom()));
      write_reg(peshg_pkg::REG_DATA_ALIGNED, 8'($urandom()));
      write_reg(peshg_pkg::REG_FIXED_HDR_LEN, {2'($urandom()), 6'(fx)});
      no_gaps = (p % 3 == 1);
      for (int i = 0; i < ItemsPerPhase; i++) req_q.push_back(rand_req());
      wait_idle();
    end

    $display("%0d requests sent, %0d headers and %0d bytes checked",
             req_cnt, hdr_cnt, byte_cnt);
    $display("%0d register writes across directed and %0d random settings",
             cfg_cnt, RandPhases);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
